@@ rtl/core/pss_pkg.sv @@
// Shared constants, control word types and microprogram for the swap sequence block.
`timescale 1ns / 1ps
`default_nettype none

package pss_pkg;

    localparam int SEQ_LEN      = 16;
    localparam int VALUE_BITS   = 8;
    localparam int IDX_BITS     = $clog2(SEQ_LEN);
    localparam int CNT_BITS     = $clog2(SEQ_LEN + 1);
    localparam int MAX_RESULTS  = 15;
    localparam int RES_BITS     = $clog2(MAX_RESULTS + 1);
    localparam int OUT_IDX_BITS = 4;
    localparam int PC_BITS      = 3;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INIT,
        OP_MATCH,
        OP_SWAP,
        OP_ADV,
        OP_FINAL
    } op_t;

    typedef enum logic [1:0] {
        C_NEXT,
        C_WAIT_LAST,
        C_WAIT_OUT,
        C_LOOP
    } cond_t;

    typedef struct packed {
        logic                 in_ready;
        op_t                  op;
        cond_t                cond;
        logic [PC_BITS-1:0]   target;
    } ctrl_t;

    typedef struct packed {
        logic last_in;
        logic stall;
        logic more;
    } stat_t;

    localparam logic [PC_BITS-1:0] PC_LOAD  = 3'd0;
    localparam logic [PC_BITS-1:0] PC_INIT  = 3'd1;
    localparam logic [PC_BITS-1:0] PC_MATCH = 3'd2;
    localparam logic [PC_BITS-1:0] PC_SWAP  = 3'd3;
    localparam logic [PC_BITS-1:0] PC_ADV   = 3'd4;
    localparam logic [PC_BITS-1:0] PC_FINAL = 3'd5;

    // Microprogram ROM
    function automatic ctrl_t ucode(input logic [PC_BITS-1:0] pc);
        ctrl_t w;
        begin
            w = '{in_ready: 1'b0, op: OP_NONE, cond: C_NEXT, target: PC_LOAD};
            case (pc)
                PC_LOAD: begin
                    w = '{in_ready: 1'b1, op: OP_NONE, cond: C_WAIT_LAST, target: PC_LOAD};
                end
                PC_INIT: begin
                    w = '{in_ready: 1'b0, op: OP_INIT, cond: C_NEXT, target: PC_LOAD};
                end
                PC_MATCH: begin
                    w = '{in_ready: 1'b0, op: OP_MATCH, cond: C_NEXT, target: PC_LOAD};
                end
                PC_SWAP: begin
                    w = '{in_ready: 1'b0, op: OP_SWAP, cond: C_WAIT_OUT, target: PC_ADV};
                end
                PC_ADV: begin
                    w = '{in_ready: 1'b0, op: OP_ADV, cond: C_LOOP, target: PC_MATCH};
                end
                PC_FINAL: begin
                    w = '{in_ready: 1'b0, op: OP_FINAL, cond: C_WAIT_OUT, target: PC_LOAD};
                end
                default: begin
                    w = '{in_ready: 1'b0, op: OP_NONE, cond: C_WAIT_OUT, target: PC_LOAD};
                end
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pss_sequencer.sv @@
// Step counter and jump logic that walks the microprogram.
`timescale 1ns / 1ps
`default_nettype none

module pss_sequencer (
    input  wire            aclk,
    input  wire            aresetn,
    input  pss_pkg::stat_t stat,
    output pss_pkg::ctrl_t ctrl
);
    import pss_pkg::*;

    logic [PC_BITS-1:0] pc_reg;
    logic [PC_BITS-1:0] pc_next;

    assign ctrl = ucode(pc_reg);

    always_comb begin
        case (ctrl.cond)
            C_NEXT:      pc_next = pc_reg + PC_BITS'(1);
            C_WAIT_LAST: pc_next = stat.last_in ? pc_reg + PC_BITS'(1) : pc_reg;
            C_WAIT_OUT:  pc_next = stat.stall ? pc_reg : ctrl.target;
            C_LOOP:      pc_next = stat.more ? ctrl.target : pc_reg + PC_BITS'(1);
            default:     pc_next = PC_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_LOAD;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pss_datapath.sv @@
// Sequence stores, parallel match, swap, pending result and output register.
`timescale 1ns / 1ps
`default_nettype none

module pss_datapath (
    input  wire             aclk,
    input  wire             aresetn,
    input  pss_pkg::ctrl_t  ctrl,
    output pss_pkg::stat_t  stat,
    input  wire             s_tvalid,
    output logic            s_tready,
    input  wire [15:0]      s_tdata,   // [7:0] src_value, [15:8] tgt_value
    input  wire             s_tlast,
    output logic            m_tvalid,
    input  wire             m_tready,
    output logic [7:0]      m_tdata,   // [3:0] first_index, [7:4] second_index
    output logic            m_tuser,   // [0] found
    output logic            m_tlast
);
    import pss_pkg::*;

    logic [VALUE_BITS-1:0]   src_reg [SEQ_LEN];
    logic [VALUE_BITS-1:0]   tgt_reg [SEQ_LEN];
    logic [CNT_BITS-1:0]     load_cnt_reg;
    logic [IDX_BITS-1:0]     i_reg;
    logic [RES_BITS-1:0]     cnt_reg;
    logic                    hit_reg;
    logic [IDX_BITS-1:0]     j_reg;
    logic [VALUE_BITS-1:0]   src_i_reg;
    logic [VALUE_BITS-1:0]   tgt_i_reg;
    logic                    pend_valid_reg;
    logic [IDX_BITS-1:0]     pend_i_reg;
    logic [IDX_BITS-1:0]     pend_j_reg;
    logic                    m_valid_reg;
    logic [OUT_IDX_BITS-1:0] m_first_reg;
    logic [OUT_IDX_BITS-1:0] m_second_reg;
    logic                    m_found_reg;
    logic                    m_last_reg;

    logic                    in_acc;
    logic                    out_free;
    logic                    need_push;
    logic                    stall;
    logic                    more;
    logic                    swap_fire;
    logic                    final_fire;
    logic                    push_pend;
    logic [SEQ_LEN-1:0]      match;
    logic                    hit;
    logic [IDX_BITS-1:0]     j_sel;
    logic [VALUE_BITS-1:0]   tgt_i;

    assign s_tready = ctrl.in_ready;
    assign in_acc   = s_tvalid && ctrl.in_ready;
    assign out_free = !m_valid_reg || m_tready;

    assign need_push = ((ctrl.op == OP_SWAP) && hit_reg && pend_valid_reg)
                     || (ctrl.op == OP_FINAL);
    assign stall      = need_push && !out_free;
    assign swap_fire  = (ctrl.op == OP_SWAP) && !stall && hit_reg;
    assign final_fire = (ctrl.op == OP_FINAL) && !stall;
    assign push_pend  = swap_fire && pend_valid_reg;
    assign more = ((CNT_BITS'(i_reg) + CNT_BITS'(1)) < load_cnt_reg)
               && (cnt_reg < RES_BITS'(MAX_RESULTS));

    assign stat = '{last_in: in_acc && s_tlast, stall: stall, more: more};

    assign tgt_i = tgt_reg[i_reg];

    always_comb begin
        for (int j = 0; j < SEQ_LEN; j++) begin
            match[j] = (IDX_BITS'(j) != i_reg) && (CNT_BITS'(j) < load_cnt_reg)
                    && (src_reg[j] == tgt_i);
        end
    end

    // lowest matching position
    always_comb begin
        hit   = |match;
        j_sel = '0;
        for (int j = SEQ_LEN - 1; j >= 0; j--) begin
            if (match[j]) begin
                j_sel = IDX_BITS'(j);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_cnt_reg   <= '0;
            i_reg          <= '0;
            cnt_reg        <= '0;
            hit_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (in_acc && (load_cnt_reg < CNT_BITS'(SEQ_LEN))) begin
                load_cnt_reg <= load_cnt_reg + CNT_BITS'(1);
            end
            if (ctrl.op == OP_INIT) begin
                i_reg          <= '0;
                cnt_reg        <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (ctrl.op == OP_MATCH) begin
                hit_reg <= hit;
            end
            if (swap_fire) begin
                cnt_reg        <= cnt_reg + RES_BITS'(1);
                pend_valid_reg <= 1'b1;
            end
            if ((ctrl.op == OP_ADV) && more) begin
                i_reg <= i_reg + IDX_BITS'(1);
            end
            if (final_fire) begin
                load_cnt_reg   <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (push_pend || final_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && (load_cnt_reg < CNT_BITS'(SEQ_LEN))) begin
            src_reg[load_cnt_reg[IDX_BITS-1:0]] <= VALUE_BITS'(s_tdata[7:0]);
            tgt_reg[load_cnt_reg[IDX_BITS-1:0]] <= VALUE_BITS'(s_tdata[15:8]);
        end
        if (ctrl.op == OP_MATCH) begin
            j_reg     <= j_sel;
            src_i_reg <= src_reg[i_reg];
            tgt_i_reg <= tgt_i;
        end
        if (swap_fire) begin
            src_reg[i_reg] <= tgt_i_reg;
            src_reg[j_reg] <= src_i_reg;
            pend_i_reg     <= i_reg;
            pend_j_reg     <= j_reg;
        end
        if (push_pend) begin
            m_first_reg  <= OUT_IDX_BITS'(pend_i_reg);
            m_second_reg <= OUT_IDX_BITS'(pend_j_reg);
            m_found_reg  <= 1'b1;
            m_last_reg   <= 1'b0;
        end else if (final_fire) begin
            m_first_reg  <= pend_valid_reg ? OUT_IDX_BITS'(pend_i_reg) : '0;
            m_second_reg <= pend_valid_reg ? OUT_IDX_BITS'(pend_j_reg) : '0;
            m_found_reg  <= pend_valid_reg;
            m_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_second_reg, m_first_reg};
    assign m_tuser  = m_found_reg;
    assign m_tlast  = m_last_reg;

    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= RES_BITS'(MAX_RESULTS))
        else $error("result count above cap");

    a_load_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        load_cnt_reg <= CNT_BITS'(SEQ_LEN))
        else $error("load count above sequence length");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.in_ready |-> !pend_valid_reg)
        else $error("pending result left over while loading");

    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> m_last_reg)
        else $error("empty marker without final flag");

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_pend || final_fire) |-> out_free)
        else $error("output register overwritten");

endmodule

`default_nettype wire

@@ rtl/core/permutation_swap_sequence_top.sv @@
// Top level of the permutation swap sequence block.
`timescale 1ns / 1ps
`default_nettype none

// Loads up to 16 (source, target) element pairs, one transfer per cycle; the transfer
// with tlast ends the load and starts the scan. For each target position the
// microprogram runs three steps (parallel match, swap, advance), after a start step
// and before a final step that emits the final result; the swap and final steps can
// stall while the output register is full. Results leave through one output register;
// each swap result is held pending until the next swap or the final step, so the final
// one can carry tlast. A sequence without swaps gives one transfer with tuser (found) low.
// Pairs beyond the 16th are dropped, and at most 15 results are produced per sequence.
module permutation_swap_sequence_top (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [15:0] s_tdata,   // [7:0] src_value, [15:8] tgt_value
    input  wire        s_tlast,
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // [3:0] first_index, [7:4] second_index
    output logic       m_tuser,   // [0] found
    output logic       m_tlast
);
    import pss_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    pss_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    pss_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .stat     (stat),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ tb/permutation_swap_sequence_top_tb.sv @@
// Self-checking testbench for the permutation swap sequence block.
`timescale 1ns / 1ps

module permutation_swap_sequence_top_tb;
    import pss_pkg::*;

    typedef struct packed {
        logic [OUT_IDX_BITS-1:0] first_idx;
        logic [OUT_IDX_BITS-1:0] second_idx;
        logic                    found;
        logic                    last_swap;
    } swap_t;

    typedef struct {
        logic [VALUE_BITS-1:0] src;
        logic [VALUE_BITS-1:0] tgt;
        logic                  last;
        bit                    typed;
        swap_t                 res;
    } pair_row_t;

    typedef enum int {
        SEQ_PERM,
        SEQ_FEW,
        SEQ_WIDE
    } seq_kind_t;

    localparam swap_t NO_SWAP = '{first_idx: '0, second_idx: '0, found: 1'b0, last_swap: 1'b1};
    localparam int    MAX_LEN = SEQ_LEN + 4;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;   // [7:0] src_value, [15:8] tgt_value
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [7:0]  m_tdata;         // [3:0] first_index, [7:4] second_index
    wire         m_tuser;         // [0] found
    wire         m_tlast;

    logic [VALUE_BITS-1:0] src_mem [SEQ_LEN];
    logic [VALUE_BITS-1:0] tgt_mem [SEQ_LEN];
    int unsigned           pair_cnt = 0;
    swap_t                 swap_q[$];
    int unsigned           err_cnt  = 0;
    int unsigned           idle_pct = 0;

    permutation_swap_sequence_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stores one pair; on the closing pair, scans and, if asked, queues the swap list.
    function automatic void model_pair(input logic [VALUE_BITS-1:0] src,
                                       input logic [VALUE_BITS-1:0] tgt,
                                       input logic last, input bit queue_it);
        swap_t                 pend [MAX_RESULTS];
        logic [VALUE_BITS-1:0] tmp;
        int                    n;
        int                    cnt;
        int                    i;
        int                    j;
        bit                    hit;
        cnt = 0;
        if (pair_cnt < SEQ_LEN) begin
            src_mem[pair_cnt] = src;
            tgt_mem[pair_cnt] = tgt;
            pair_cnt++;
        end
        if (!last)
            return;
        n = pair_cnt;
        for (i = 0; i < n; i++) begin
            hit = 1'b0;
            for (j = 0; j < n && !hit; j++) begin
                if (j != i && src_mem[j] == tgt_mem[i]) begin
                    tmp        = src_mem[i];
                    src_mem[i] = src_mem[j];
                    src_mem[j] = tmp;
                    if (cnt < MAX_RESULTS) begin
                        pend[cnt] = '{first_idx: OUT_IDX_BITS'(i), second_idx: OUT_IDX_BITS'(j),
                                      found: 1'b1, last_swap: 1'b0};
                        cnt++;
                    end
                    hit = 1'b1;
                end
            end
        end
        pair_cnt = 0;
        if (!queue_it)
            return;
        if (cnt == 0) begin
            swap_q = {swap_q, NO_SWAP};
        end else begin
            pend[cnt-1].last_swap = 1'b1;
            for (i = 0; i < cnt; i++)
                swap_q = {swap_q, pend[i]};
        end
    endfunction

    function automatic pair_row_t mk_row(input logic [VALUE_BITS-1:0] src,
                                         input logic [VALUE_BITS-1:0] tgt,
                                         input logic last, input bit typed, input swap_t res);
        pair_row_t row;
        row.src   = src;
        row.tgt   = tgt;
        row.last  = last;
        row.typed = typed;
        row.res   = res;
        return row;
    endfunction

    task automatic send_pair(input logic [VALUE_BITS-1:0] src, input logic [VALUE_BITS-1:0] tgt,
                             input logic last, input bit typed, input swap_t res);
        s_tvalid <= 1'b1;
        s_tdata  <= {tgt, src};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        model_pair(src, tgt, last, !typed);
        if (typed)
            swap_q = {swap_q, res};
        if ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic send_seq(input seq_kind_t kind, input int len);
        logic [VALUE_BITS-1:0] sv [MAX_LEN];
        logic [VALUE_BITS-1:0] tv [MAX_LEN];
        logic [VALUE_BITS-1:0] tmp;
        int                    k;
        int                    m;
        int                    base;
        int                    stride;
        base   = $urandom_range(0, 255);
        stride = 2 * $urandom_range(0, 127) + 1;
        for (k = 0; k < len; k++) begin
            case (kind)
                SEQ_PERM: begin
                    tv[k] = VALUE_BITS'(base + k * stride);
                    sv[k] = tv[k];
                end
                SEQ_FEW: begin
                    tv[k] = VALUE_BITS'(base + $urandom_range(0, 3));
                    sv[k] = VALUE_BITS'(base + $urandom_range(0, 3));
                end
                default: begin
                    tv[k] = VALUE_BITS'($urandom_range(0, 255));
                    sv[k] = VALUE_BITS'($urandom_range(0, 255));
                end
            endcase
        end
        // shuffle the source values, a copy of the target, into a random order
        if (kind == SEQ_PERM) begin
            for (k = len - 1; k > 0; k--) begin
                m     = $urandom_range(0, k);
                tmp   = sv[k];
                sv[k] = sv[m];
                sv[m] = tmp;
            end
        end
        for (k = 0; k < len; k++)
            send_pair(sv[k], tv[k], k == len - 1, 1'b0, NO_SWAP);
    endtask

    initial begin
        pair_row_t rows[$];
        int        sent;
        int        len;
        int        pick;
        int        k;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rows = {rows, mk_row(8'h00, 8'h00, 1'b1, 1'b1, NO_SWAP)};
        rows = {rows, mk_row(8'hFF, 8'h00, 1'b0, 1'b0, NO_SWAP)};
        rows = {rows, mk_row(8'h00, 8'hFF, 1'b1, 1'b1,
                             '{first_idx: 4'd0, second_idx: 4'd1, found: 1'b1, last_swap: 1'b1})};
        // equal values already in place still swap
        rows = {rows, mk_row(8'h5A, 8'h5A, 1'b0, 1'b0, NO_SWAP)};
        rows = {rows, mk_row(8'h5A, 8'h5A, 1'b1, 1'b0, NO_SWAP)};
        rows = {rows, mk_row(8'h10, 8'h30, 1'b0, 1'b0, NO_SWAP)};
        rows = {rows, mk_row(8'h20, 8'h20, 1'b0, 1'b0, NO_SWAP)};
        rows = {rows, mk_row(8'h30, 8'h10, 1'b1, 1'b0, NO_SWAP)};
        // full load of duplicates: result cap, then a dropped pair that closes the load
        for (k = 0; k < SEQ_LEN; k++)
            rows = {rows, mk_row(8'hFF, 8'hFF, 1'b0, 1'b0, NO_SWAP)};
        rows = {rows, mk_row(8'h00, 8'h00, 1'b1, 1'b0, NO_SWAP)};

        idle_pct = 20;
        foreach (rows[r])
            send_pair(rows[r].src, rows[r].tgt, rows[r].last, rows[r].typed, rows[r].res);

        sent = 0;
        while (sent < 235) begin
            if (sent > 200) begin
                idle_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end
            pick = $urandom_range(0, 99);
            len  = $urandom_range(1, SEQ_LEN);
            if (pick < 55) begin
                send_seq(SEQ_PERM, len);
            end else if (pick < 80) begin
                send_seq(SEQ_FEW, len);
            end else if (pick < 92) begin
                send_seq(SEQ_WIDE, len);
            end else begin
                len = $urandom_range(SEQ_LEN + 1, MAX_LEN);
                send_seq(SEQ_FEW, len);
            end
            sent += len;
        end
        s_tvalid <= 1'b0;

        while (swap_q.size() != 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        swap_t got;
        swap_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{first_idx: m_tdata[3:0], second_idx: m_tdata[7:4],
                    found: m_tuser, last_swap: m_tlast};
            if (swap_q.size() == 0) begin
                err_cnt++;
                $display("%0t: transfer with none expected, actual i=%0d j=%0d found=%b last=%b",
                         $time, got.first_idx, got.second_idx, got.found, got.last_swap);
            end else begin
                want = swap_q.pop_front();
                if (got.first_idx !== want.first_idx || got.second_idx !== want.second_idx ||
                    got.found !== want.found || got.last_swap !== want.last_swap) begin
                    err_cnt++;
                    $display("%0t: expected i=%0d j=%0d found=%b last=%b, %s",
                             $time, want.first_idx, want.second_idx, want.found,
                             want.last_swap,
                             $sformatf("actual i=%0d j=%0d found=%b last=%b",
                                       got.first_idx, got.second_idx, got.found,
                                       got.last_swap));
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
